[rtl/rrtt_pkg.sv]
// rrtt_pkg: shared widths, command codes and controller states for the
// round-robin task table. No dependencies.
`default_nettype none

package rrtt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int CMD_W         = 2;
  localparam int ENTRY_W       = 48;
  localparam int OUT_SLOT_W    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_SCHED  = 2'd2,
    CMD_START  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_READ,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

[rtl/rrtt_if.sv]
// rrtt_if: valid/ready channel interfaces for command beats and result beats.
// Depends on rrtt_pkg for field widths.
`default_nettype none

interface rrtt_in_if import rrtt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ENTRY_W-1:0] entry_address;

  modport source (output valid, command, entry_address, input ready);
  modport sink (input valid, command, entry_address, output ready);
endinterface

interface rrtt_out_if import rrtt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_SLOT_W-1:0] slot;
  logic [OUT_SLOT_W-1:0] previous_slot;
  logic                  success;
  logic [ENTRY_W-1:0]    task_entry;

  modport source (output valid, slot, previous_slot, success, task_entry, input ready);
  modport sink (input valid, slot, previous_slot, success, task_entry, output ready);
endinterface

`default_nettype wire

[rtl/round_robin_task_table_unit.sv]
// round_robin_task_table_unit: top level of the round-robin task table.
// Depends on rrtt_pkg, rrtt_if and rrtt_entry_ram.
//
//   channel   dir  beat contents
//   in_item   in   command, entry_address
//   out_item  out  slot, previous_slot, success, task_entry
//
// clear: result goes straight to the output register; create: one ready
// bit tested per cycle; schedule: one slot stepped per cycle, then the
// entry ram read; start: the entry ram read only.
// reset is synchronous; ready bits gate the entry ram, so no clearing pass.
// one command in flight; a new beat is taken while a result waits in the
// output register, and a stalled output holds the controller in its last state.
`default_nettype none

module round_robin_task_table_unit import rrtt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rrtt_in_if.sink     in_item,
  rrtt_out_if.source  out_item
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  state_t               state_r, state_nxt;
  logic [NUM_SLOTS-1:0] ready_r, ready_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic                 out_valid_r;

  logic [ENTRY_W-1:0]   addr_r;
  logic [SW-1:0]        prev_r;
  logic [SW-1:0]        scan_idx_r;
  logic [SW-1:0]        walk_r;
  logic [SW-1:0]        step_r;
  logic [SW-1:0]        res_slot_r;
  logic                 res_ok_r;
  logic [ENTRY_W-1:0]   res_entry_r;
  logic                 from_mem_r;

  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic [OUT_SLOT_W-1:0] out_prev_r;
  logic                  out_success_r;
  logic [ENTRY_W-1:0]    out_entry_r;

  cmd_t                 cmd;
  logic                 accept;
  logic                 in_ready;
  logic                 scan_hit;
  logic                 scan_last;
  logic                 walk_done;
  logic [SW-1:0]        walk_nxt;
  logic                 out_load;
  logic [ENTRY_W-1:0]   rdata;
  logic [SW+OUT_SLOT_W-1:0] slot_ext;
  logic [SW+OUT_SLOT_W-1:0] prev_ext;

  assign cmd       = cmd_t'(in_item.command);
  assign accept    = in_item.valid && in_ready;
  assign scan_last = (scan_idx_r == SW'(NUM_SLOTS - 1));
  assign walk_nxt  = ((CW'(walk_r) + CW'(1)) == count_r) ? '0 : walk_r + SW'(1);
  assign walk_done = ready_r[walk_nxt] || ((CW'(step_r) + CW'(1)) == count_r);
  assign slot_ext  = {{OUT_SLOT_W{1'b0}}, res_slot_r};
  assign prev_ext  = {{OUT_SLOT_W{1'b0}}, prev_r};

  rrtt_entry_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (SW),
    .DW    (ENTRY_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (scan_hit),
    .waddr (scan_idx_r),
    .wdata (addr_r),
    .raddr (res_slot_r),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          case (cmd)
            CMD_CLEAR:  state_nxt = ST_OUT;
            CMD_CREATE: state_nxt = ST_SCAN;
            CMD_SCHED:  state_nxt = (count_r == '0) ? ST_READ : ST_WALK;
            CMD_START:  state_nxt = ST_READ;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!ready_r[scan_idx_r] || scan_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_item.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready = 1'b0;
    scan_hit = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: scan_hit = !ready_r[scan_idx_r];
      ST_OUT:  out_load = !out_valid_r || out_item.ready;
      default: ;
    endcase
  end

  // table state updates
  always_comb begin
    ready_nxt = ready_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    if (accept && cmd == CMD_CLEAR) begin
      ready_nxt = '0;
    end
    if (accept && cmd == CMD_START) begin
      cur_nxt = '0;
    end
    if (scan_hit) begin
      ready_nxt[scan_idx_r] = 1'b1;
      if (count_r != CW'(NUM_SLOTS)) begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (state_r == ST_WALK && walk_done) begin
      cur_nxt = walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= '0;
      count_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_item.entry_address;
      prev_r <= cur_r;
      case (cmd)
        CMD_CLEAR: begin
          res_slot_r  <= cur_r;
          res_ok_r    <= 1'b1;
          res_entry_r <= '0;
          from_mem_r  <= 1'b0;
        end
        CMD_CREATE: begin
          scan_idx_r <= '0;
        end
        CMD_SCHED: begin
          walk_r     <= cur_r;
          step_r     <= '0;
          res_slot_r <= cur_r;
          res_ok_r   <= 1'b0;
          from_mem_r <= 1'b1;
        end
        CMD_START: begin
          res_slot_r <= '0;
          res_ok_r   <= 1'b1;
          from_mem_r <= 1'b1;
        end
        default: ;
      endcase
    end
    if (state_r == ST_SCAN) begin
      if (scan_hit) begin
        res_slot_r  <= scan_idx_r;
        res_ok_r    <= 1'b1;
        res_entry_r <= addr_r;
        from_mem_r  <= 1'b0;
      end else if (scan_last) begin
        res_slot_r  <= '0;
        res_ok_r    <= 1'b0;
        res_entry_r <= '0;
        from_mem_r  <= 1'b0;
      end else begin
        scan_idx_r <= scan_idx_r + SW'(1);
      end
    end
    if (state_r == ST_WALK) begin
      if (walk_done) begin
        res_slot_r <= walk_nxt;
        res_ok_r   <= (walk_nxt != cur_r);
      end else begin
        walk_r <= walk_nxt;
        step_r <= step_r + SW'(1);
      end
    end
    if (out_load) begin
      out_slot_r    <= slot_ext[OUT_SLOT_W-1:0];
      out_prev_r    <= prev_ext[OUT_SLOT_W-1:0];
      out_success_r <= res_ok_r;
      if (from_mem_r) begin
        out_entry_r <= ready_r[res_slot_r] ? rdata : '0;
      end else begin
        out_entry_r <= res_entry_r;
      end
    end
  end

  assign in_item.ready          = in_ready;
  assign out_item.valid         = out_valid_r;
  assign out_item.slot          = out_slot_r;
  assign out_item.previous_slot = out_prev_r;
  assign out_item.success       = out_success_r;
  assign out_item.task_entry    = out_entry_r;

  // current slot stays inside the active range
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) ? (cur_r == '0) : (CW'(cur_r) < count_r))
    else $error("current slot outside active range");

  // active count never falls and never passes the table size
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r >= $past(count_r)) && (count_r <= CW'(NUM_SLOTS)))
    else $error("active count went backwards or overflowed");

  // a schedule walk only runs with tasks counted
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (count_r != '0))
    else $error("walk with zero active count");

  // a claimed slot is ready on the following cycle
  a_claim_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    scan_hit |=> ready_r[$past(scan_idx_r)])
    else $error("claimed slot not marked ready");

  // no new beat is taken while a command is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("beat accepted while busy");

endmodule

`default_nettype wire

[rtl/rrtt_entry_ram.sv]
// rrtt_entry_ram: single-write, single-read synchronous memory holding the
// task entry addresses, read data registered. No dependencies.
`default_nettype none

module rrtt_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 48
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
